@@ design/brt_pkg.sv @@
// shared types, constants and byte classes for the bracket raw string tokenizer
`timescale 1ns / 1ps

package brt_pkg;

  // sizes
  localparam int MAX_DELIM   = 16;
  localparam int OFFSET_BITS = 32;
  localparam int DLEN_W      = $clog2(MAX_DELIM + 1);
  localparam int DIDX_W      = (MAX_DELIM > 1) ? $clog2(MAX_DELIM) : 1;
  localparam int QDEPTH      = 4;
  localparam int QPTR_W      = $clog2(QDEPTH);
  localparam int SLOTS       = 3;

  localparam logic [DLEN_W-1:0]      DLEN_MAX = DLEN_W'(MAX_DELIM);
  localparam logic [DLEN_W-1:0]      DLEN_ONE = DLEN_W'(1);
  localparam logic [QPTR_W:0]        QPTR_ONE = {{QPTR_W{1'b0}}, 1'b1};
  localparam logic [OFFSET_BITS-1:0] OFS_ZERO = '0;
  localparam logic [OFFSET_BITS-1:0] OFS_ONE  = OFFSET_BITS'(1);

  // token kinds
  localparam logic [2:0] KIND_LEFT  = 3'd0;
  localparam logic [2:0] KIND_RIGHT = 3'd1;
  localparam logic [2:0] KIND_BASIC = 3'd2;
  localparam logic [2:0] KIND_RAW   = 3'd3;
  localparam logic [2:0] KIND_ERROR = 3'd4;
  localparam logic [2:0] KIND_END   = 3'd5;

  // special bytes
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_RBRACK = 8'h5D;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_R      = 8'h52;
  localparam logic [7:0] CH_QUOTE  = 8'h22;

  // scanner modes
  typedef enum logic [2:0] {
    MODE_IDLE,
    MODE_BASIC,
    MODE_SAWR,
    MODE_DELIM,
    MODE_CONTENT,
    MODE_SUFFIX,
    MODE_ERROR
  } mode_t;

  // one token
  typedef struct packed {
    logic [2:0]             kind;
    logic [OFFSET_BITS-1:0] offset;
    logic [OFFSET_BITS-1:0] length;
  } tok_t;

  // all tokens caused by one byte
  typedef struct packed {
    logic [1:0]            cnt;
    tok_t [SLOTS-1:0]      tok;
  } bundle_t;

  // whitespace skipped between tokens
  function automatic logic is_space(input logic [7:0] b);
    is_space = (b == 8'd9) || (b == 8'd10) || (b == 8'd12) ||
               (b == 8'd13) || (b == 8'd32);
  endfunction

  // printable non-bracket bytes
  function automatic logic is_text(input logic [7:0] b);
    logic bad;
    bad = (b <= 8'h20) || (b == 8'h7F) || (b == CH_LBRACK) || (b == CH_RBRACK) ||
          ((b >= 8'h80) && (b <= 8'h9F)) || (b >= 8'hFE);
    is_text = !bad;
  endfunction

endpackage

@@ design/brt_front.sv @@
// front scanner: classifies each byte and builds the bundle of tokens it causes
`timescale 1ns / 1ps

module brt_front (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      acc,
  input  logic [7:0]                data_byte,
  input  logic                      final_byte,
  output logic                      push,
  output brt_pkg::bundle_t          bundle
);

  // scanner state
  brt_pkg::mode_t                       mode_r, mode_nxt;
  logic [brt_pkg::OFFSET_BITS-1:0]      pos_r, pos_nxt;
  logic [brt_pkg::OFFSET_BITS-1:0]      tb_r, tb_nxt;
  logic [brt_pkg::OFFSET_BITS-1:0]      cb_r, cb_nxt;
  logic [brt_pkg::OFFSET_BITS-1:0]      cp_r, cp_nxt;
  logic [brt_pkg::DLEN_W-1:0]           dlen_r, dlen_nxt;
  logic [brt_pkg::DLEN_W-1:0]           sidx_r, sidx_nxt;
  logic                                 smatch_r, smatch_nxt;
  logic [7:0]                           store_r [brt_pkg::MAX_DELIM];

  // decoded byte and prelude
  logic                                 txt, spc;
  logic                                 sawr_quote, basic_like, basic_cont, basic_cut, done;
  brt_pkg::mode_t                       case_mode, mid_mode;
  logic [brt_pkg::OFFSET_BITS-1:0]      tb_mid, pos_inc;
  logic                                 st_we;
  logic [7:0]                           st_rd;
  logic                                 raw_hit;

  assign txt     = brt_pkg::is_text(data_byte);
  assign spc     = brt_pkg::is_space(data_byte);
  assign pos_inc = pos_r + brt_pkg::OFS_ONE;
  assign st_rd   = store_r[sidx_r[brt_pkg::DIDX_W-1:0]];

  // lone R and basic string handling before the main dispatch
  always_comb begin
    sawr_quote = (mode_r == brt_pkg::MODE_SAWR) && (data_byte == brt_pkg::CH_QUOTE);
    basic_like = (mode_r == brt_pkg::MODE_BASIC) ||
                 ((mode_r == brt_pkg::MODE_SAWR) && (data_byte != brt_pkg::CH_QUOTE));
    basic_cont = basic_like && txt;
    basic_cut  = basic_like && !txt;
    done       = sawr_quote || basic_cont;
    case_mode  = basic_cut ? brt_pkg::MODE_IDLE : mode_r;
    raw_hit    = (data_byte == brt_pkg::CH_QUOTE) && smatch_r && (sidx_r == dlen_r);
  end

  // next state
  always_comb begin
    mid_mode   = mode_r;
    tb_mid     = tb_r;
    cb_nxt     = cb_r;
    cp_nxt     = cp_r;
    dlen_nxt   = dlen_r;
    sidx_nxt   = sidx_r;
    smatch_nxt = smatch_r;
    st_we      = 1'b0;
    if (sawr_quote) begin
      mid_mode = brt_pkg::MODE_DELIM;
      dlen_nxt = '0;
    end else if (basic_cont) begin
      mid_mode = brt_pkg::MODE_BASIC;
    end else begin
      mid_mode = case_mode;
      unique case (case_mode)
        brt_pkg::MODE_IDLE: begin
          if (data_byte == brt_pkg::CH_LBRACK || data_byte == brt_pkg::CH_RBRACK || spc) begin
            mid_mode = brt_pkg::MODE_IDLE;
          end else if (txt) begin
            tb_mid   = pos_r;
            mid_mode = (data_byte == brt_pkg::CH_R) ? brt_pkg::MODE_SAWR : brt_pkg::MODE_BASIC;
          end else begin
            mid_mode = brt_pkg::MODE_ERROR;
          end
        end
        brt_pkg::MODE_DELIM: begin
          if (data_byte == brt_pkg::CH_LPAREN) begin
            cb_nxt   = pos_inc;
            mid_mode = brt_pkg::MODE_CONTENT;
          end else if (dlen_r >= brt_pkg::DLEN_MAX) begin
            mid_mode = brt_pkg::MODE_ERROR;
          end else begin
            st_we    = 1'b1;
            dlen_nxt = dlen_r + brt_pkg::DLEN_ONE;
          end
        end
        brt_pkg::MODE_CONTENT: begin
          if (data_byte == brt_pkg::CH_RPAREN) begin
            cp_nxt     = pos_r;
            sidx_nxt   = '0;
            smatch_nxt = 1'b1;
            mid_mode   = brt_pkg::MODE_SUFFIX;
          end
        end
        brt_pkg::MODE_SUFFIX: begin
          if (data_byte == brt_pkg::CH_QUOTE) begin
            mid_mode = raw_hit ? brt_pkg::MODE_IDLE : brt_pkg::MODE_CONTENT;
          end else if (smatch_r) begin
            if (sidx_r < dlen_r && data_byte == st_rd) begin
              sidx_nxt = sidx_r + brt_pkg::DLEN_ONE;
            end else begin
              smatch_nxt = 1'b0;
            end
          end
        end
        default: begin
          mid_mode = case_mode;
        end
      endcase
    end
    // the final byte returns everything to reset
    if (final_byte) begin
      mode_nxt   = brt_pkg::MODE_IDLE;
      pos_nxt    = '0;
      tb_nxt     = '0;
      cb_nxt     = '0;
      cp_nxt     = '0;
      dlen_nxt   = '0;
      sidx_nxt   = '0;
      smatch_nxt = 1'b0;
    end else begin
      mode_nxt   = mid_mode;
      pos_nxt    = pos_inc;
      tb_nxt     = tb_mid;
    end
  end

  // tokens caused by this byte, in order
  always_comb begin
    brt_pkg::tok_t [3:0] cand;
    logic [3:0]          cand_en;
    logic [1:0]          cnt_v;
    logic                fin_err;
    cand    = '0;
    cand_en = '0;
    bundle  = '0;
    cnt_v   = '0;
    fin_err = 1'b0;
    // basic string ended by a non-text byte
    cand_en[0] = basic_cut;
    cand[0]    = '{brt_pkg::KIND_BASIC, tb_r, pos_r - tb_r};
    // token from the main dispatch
    if (!done) begin
      unique case (case_mode)
        brt_pkg::MODE_IDLE: begin
          if (data_byte == brt_pkg::CH_LBRACK) begin
            cand_en[1] = 1'b1;
            cand[1]    = '{brt_pkg::KIND_LEFT, pos_r, brt_pkg::OFS_ONE};
          end else if (data_byte == brt_pkg::CH_RBRACK) begin
            cand_en[1] = 1'b1;
            cand[1]    = '{brt_pkg::KIND_RIGHT, pos_r, brt_pkg::OFS_ONE};
          end else if (!spc && !txt) begin
            cand_en[1] = 1'b1;
            cand[1]    = '{brt_pkg::KIND_ERROR, pos_r, brt_pkg::OFS_ZERO};
          end
        end
        brt_pkg::MODE_DELIM: begin
          if (data_byte != brt_pkg::CH_LPAREN && dlen_r >= brt_pkg::DLEN_MAX) begin
            cand_en[1] = 1'b1;
            cand[1]    = '{brt_pkg::KIND_ERROR, tb_r, pos_inc - tb_r};
          end
        end
        brt_pkg::MODE_SUFFIX: begin
          if (raw_hit) begin
            cand_en[1] = 1'b1;
            cand[1]    = '{brt_pkg::KIND_RAW, cb_r, cp_r - cb_r};
          end
        end
        default: begin
          cand_en[1] = 1'b0;
        end
      endcase
    end
    // open token closed by the final byte, then the end marker unless in error
    if (final_byte) begin
      if (mid_mode == brt_pkg::MODE_BASIC || mid_mode == brt_pkg::MODE_SAWR) begin
        cand_en[2] = 1'b1;
        cand[2]    = '{brt_pkg::KIND_BASIC, tb_mid, pos_inc - tb_mid};
      end else if (mid_mode == brt_pkg::MODE_DELIM || mid_mode == brt_pkg::MODE_CONTENT ||
                   mid_mode == brt_pkg::MODE_SUFFIX) begin
        cand_en[2] = 1'b1;
        cand[2]    = '{brt_pkg::KIND_ERROR, tb_mid, pos_inc - tb_mid};
        fin_err    = 1'b1;
      end
      cand_en[3] = !fin_err && (mid_mode != brt_pkg::MODE_ERROR);
      cand[3]    = '{brt_pkg::KIND_END, pos_inc, brt_pkg::OFS_ZERO};
    end
    // pack enabled tokens into consecutive slots
    for (int i = 0; i < 4; i++) begin
      if (cand_en[i]) begin
        bundle.tok[cnt_v] = cand[i];
        cnt_v = cnt_v + 2'd1;
      end
    end
    bundle.cnt = cnt_v;
  end

  assign push = acc && (bundle.cnt != 2'd0);

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= brt_pkg::MODE_IDLE;
      pos_r    <= '0;
      tb_r     <= '0;
      cb_r     <= '0;
      cp_r     <= '0;
      dlen_r   <= '0;
      sidx_r   <= '0;
      smatch_r <= 1'b0;
    end else if (acc) begin
      mode_r   <= mode_nxt;
      pos_r    <= pos_nxt;
      tb_r     <= tb_nxt;
      cb_r     <= cb_nxt;
      cp_r     <= cp_nxt;
      dlen_r   <= dlen_nxt;
      sidx_r   <= sidx_nxt;
      smatch_r <= smatch_nxt;
    end
  end

  // delimiter store, written in order
  always_ff @(posedge clk) begin
    if (acc && st_we) begin
      store_r[dlen_r[brt_pkg::DIDX_W-1:0]] <= data_byte;
    end
  end

endmodule

@@ design/brt_fifo.sv @@
// short queue of token bundles between the scanner and the output side
`timescale 1ns / 1ps

module brt_fifo (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  brt_pkg::bundle_t  wdata,
  output logic              full,
  input  logic              pop,
  output brt_pkg::bundle_t  rdata,
  output logic              empty
);

  brt_pkg::bundle_t          mem_r [brt_pkg::QDEPTH];
  logic [brt_pkg::QPTR_W:0]  wp_r, wp_nxt;
  logic [brt_pkg::QPTR_W:0]  rp_r, rp_nxt;

  // status from pointers with a wrap bit
  assign empty = (wp_r == rp_r);
  assign full  = (wp_r[brt_pkg::QPTR_W] != rp_r[brt_pkg::QPTR_W]) &&
                 (wp_r[brt_pkg::QPTR_W-1:0] == rp_r[brt_pkg::QPTR_W-1:0]);
  assign rdata = mem_r[rp_r[brt_pkg::QPTR_W-1:0]];

  assign wp_nxt = (push && !full) ? wp_r + brt_pkg::QPTR_ONE : wp_r;
  assign rp_nxt = (pop && !empty) ? rp_r + brt_pkg::QPTR_ONE : rp_r;

  // pointers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0;
      rp_r <= '0;
    end else begin
      wp_r <= wp_nxt;
      rp_r <= rp_nxt;
    end
  end

  // entries
  always_ff @(posedge clk) begin
    if (push && !full) begin
      mem_r[wp_r[brt_pkg::QPTR_W-1:0]] <= wdata;
    end
  end

endmodule

@@ design/brt_back.sv @@
// output side: walks the tokens of the head bundle one per request
`timescale 1ns / 1ps

module brt_back (
  input  logic              clk,
  input  logic              rst_n,
  input  brt_pkg::bundle_t  head,
  input  logic              head_empty,
  output logic              head_pop,
  output logic              out_empty,
  input  logic              out_pop,
  output logic [2:0]        out_token_kind,
  output logic [31:0]       out_token_offset,
  output logic [31:0]       out_token_length,
  output logic              out_run_last
);

  logic [1:0]     idx_r, idx_nxt;
  brt_pkg::tok_t  cur;
  logic           last;
  logic           take;

  // current token of the head bundle
  assign cur       = head.tok[idx_r];
  assign last      = (idx_r == (head.cnt - 2'd1));
  assign take      = out_pop && !head_empty;
  assign head_pop  = take && last;
  assign out_empty = head_empty;

  assign out_token_kind   = cur.kind;
  assign out_token_offset = 32'(cur.offset);
  assign out_token_length = 32'(cur.length);
  assign out_run_last     = last;

  // slot index within the bundle
  always_comb begin
    idx_nxt = idx_r;
    if (take) begin
      idx_nxt = last ? 2'd0 : idx_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= '0;
    end else begin
      idx_r <= idx_nxt;
    end
  end

endmodule

@@ design/bracket_raw_string_tokenizer_top.sv @@
// top level of the bracket and raw string tokenizer
`timescale 1ns / 1ps

// Takes one text byte per cycle (final_byte on the last one) and returns tokens
// as kind, offset and length, one per pop; run_last marks the last token that a
// byte caused. A byte is accepted in every cycle in which the four-entry bundle
// queue has room, and its tokens can be popped from the next cycle on. Each
// queue entry holds all tokens of one byte (up to three) and the output side
// gives one token per cycle, so bytes that cause two or three tokens hold the
// queue for that many pops; sustained input rate is one byte per cycle while
// the consumer keeps up. Offsets restart at zero after each final byte.

module bracket_raw_string_tokenizer_top (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_push,
  output logic         in_full,
  input  logic [7:0]   in_data_byte,
  input  logic         in_final_byte,
  output logic         out_empty,
  input  logic         out_pop,
  output logic [2:0]   out_token_kind,
  output logic [31:0]  out_token_offset,
  output logic [31:0]  out_token_length,
  output logic         out_run_last
);

  logic              acc;
  logic              q_push, q_full, q_pop, q_empty;
  brt_pkg::bundle_t  q_wdata, q_rdata;

  assign acc     = in_push && !q_full;
  assign in_full = q_full;

  // scanner
  brt_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .acc        (acc),
    .data_byte  (in_data_byte),
    .final_byte (in_final_byte),
    .push       (q_push),
    .bundle     (q_wdata)
  );

  // bundle queue
  brt_fifo u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .full  (q_full),
    .pop   (q_pop),
    .rdata (q_rdata),
    .empty (q_empty)
  );

  // token output
  brt_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .head             (q_rdata),
    .head_empty       (q_empty),
    .head_pop         (q_pop),
    .out_empty        (out_empty),
    .out_pop          (out_pop),
    .out_token_kind   (out_token_kind),
    .out_token_offset (out_token_offset),
    .out_token_length (out_token_length),
    .out_run_last     (out_run_last)
  );

endmodule

@@ test/bracket_raw_string_tokenizer_top_tb.sv @@
// testbench for the bracket and raw string tokenizer: byte stream in, checked token stream out
`timescale 1ns / 1ps

module bracket_raw_string_tokenizer_top_tb;
  import brt_pkg::*;

  localparam int HALF_PERIOD  = 2;
  localparam int RANDOM_BYTES = 335;
  localparam int LONG_HOLD    = 80;
  localparam int STALL_LIMIT  = 1000;
  localparam int DRAIN_CYCLES = 20;

  // one token as the block reports it
  typedef struct {
    logic [2:0]  kind;
    logic [31:0] offset;
    logic [31:0] length;
    logic        last;
  } token_s;

  // token predictor plus the queue of tokens still owed by the block
  class tokenizer_scoreboard;
    token_s      expected_tokens[$];
    token_s      step[3];
    int          step_n;
    int          mismatches;
    int          checked;
    int          kind_seen[6];
    mode_t       mode;
    logic [31:0] pos;
    logic [31:0] tok_start;
    logic [31:0] body_start;
    logic [31:0] close_at;
    logic [7:0]  delim[MAX_DELIM];
    int          delim_len;
    int          match_idx;
    bit          matching;

    function new();
      restart();
    endfunction

    // scanner state after reset and after every final byte
    function void restart();
      mode = MODE_IDLE;
      pos = '0;
      tok_start = '0;
      body_start = '0;
      close_at = '0;
      foreach (delim[i]) delim[i] = '0;
      delim_len = 0;
      match_idx = 0;
      matching = 0;
    endfunction

    function bit blank_byte(logic [7:0] b);
      return b == 8'd9 || b == 8'd10 || b == 8'd12 || b == 8'd13 || b == 8'd32;
    endfunction

    function bit word_byte(logic [7:0] b);
      if (b < 8'h21 || b == 8'h7F || b == CH_LBRACK || b == CH_RBRACK) return 0;
      if (b >= 8'h80 && b < 8'hA0) return 0;
      return b < 8'hFE;
    endfunction

    function void add(logic [2:0] k, logic [31:0] o, logic [31:0] l);
      step[step_n] = '{k, o, l, 1'b0};
      step_n++;
    endfunction

    // advance the scanner by one accepted byte and queue the tokens it yields
    function void scan_byte(logic [7:0] b, logic fin);
      logic [31:0] here;
      bit taken;
      here = pos;
      taken = 0;
      step_n = 0;
      // R seen at token start: a quote opens a raw string, anything else is text
      if (mode == MODE_SAWR) begin
        if (b == CH_QUOTE) begin
          mode = MODE_DELIM;
          delim_len = 0;
          taken = 1;
        end else begin
          mode = MODE_BASIC;
        end
      end
      if (!taken && mode == MODE_BASIC) begin
        if (word_byte(b)) begin
          taken = 1;
        end else begin
          add(KIND_BASIC, tok_start, here - tok_start);
          mode = MODE_IDLE;
        end
      end
      if (!taken) begin
        case (mode)
          MODE_IDLE: begin
            if (b == CH_LBRACK) begin
              add(KIND_LEFT, here, 32'd1);
            end else if (b == CH_RBRACK) begin
              add(KIND_RIGHT, here, 32'd1);
            end else if (word_byte(b)) begin
              tok_start = here;
              mode = (b == CH_R) ? MODE_SAWR : MODE_BASIC;
            end else if (!blank_byte(b)) begin
              add(KIND_ERROR, here, 32'd0);
              mode = MODE_ERROR;
            end
          end
          MODE_DELIM: begin
            if (b == CH_LPAREN) begin
              body_start = here + 32'd1;
              mode = MODE_CONTENT;
            end else if (delim_len >= MAX_DELIM) begin
              add(KIND_ERROR, tok_start, here + 32'd1 - tok_start);
              mode = MODE_ERROR;
            end else begin
              delim[delim_len] = b;
              delim_len++;
            end
          end
          MODE_CONTENT: begin
            if (b == CH_RPAREN) begin
              close_at = here;
              match_idx = 0;
              matching = 1;
              mode = MODE_SUFFIX;
            end
          end
          MODE_SUFFIX: begin
            if (b == CH_QUOTE) begin
              if (matching && match_idx == delim_len) begin
                add(KIND_RAW, body_start, close_at - body_start);
                mode = MODE_IDLE;
              end else begin
                mode = MODE_CONTENT;
              end
            end else if (matching) begin
              if (match_idx < delim_len && b == delim[match_idx]) match_idx++;
              else matching = 0;
            end
          end
          default: begin
          end
        endcase
      end
      // end of buffer: flush the open token, then the end marker unless in error
      if (fin) begin
        if (mode == MODE_BASIC || mode == MODE_SAWR) begin
          add(KIND_BASIC, tok_start, here + 32'd1 - tok_start);
        end else if (mode == MODE_DELIM || mode == MODE_CONTENT || mode == MODE_SUFFIX) begin
          add(KIND_ERROR, tok_start, here + 32'd1 - tok_start);
          mode = MODE_ERROR;
        end
        if (mode != MODE_ERROR) add(KIND_END, here + 32'd1, 32'd0);
        restart();
      end else begin
        pos = here + 32'd1;
      end
      for (int i = 0; i < step_n; i++) begin
        step[i].last = (i == step_n - 1);
        expected_tokens.push_back(step[i]);
      end
    endfunction

    function void flag(string msg);
      mismatches++;
      if (mismatches <= 10) $display("mismatch: %s", msg);
    endfunction

    // compare one popped token with the oldest prediction
    function void check_token(logic [2:0] kind, logic [31:0] offset, logic [31:0] length,
                              logic last);
      token_s want;
      checked++;
      if (expected_tokens.size() == 0) begin
        flag($sformatf("token %0d not expected: kind %0d offset %0d length %0d last %0b",
                       checked, kind, offset, length, last));
        return;
      end
      want = expected_tokens.pop_front();
      if (kind !== want.kind || offset !== want.offset || length !== want.length ||
          last !== want.last) begin
        flag($sformatf({"token %0d: expected kind %0d offset %0d length %0d last %0b, ",
                        "got kind %0d offset %0d length %0d last %0b"}, checked, want.kind,
                       want.offset, want.length, want.last, kind, offset, length, last));
      end else begin
        kind_seen[want.kind]++;
      end
    endfunction

    function int outstanding();
      return expected_tokens.size();
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_push = 1'b0;
  logic        in_full;
  logic [7:0]  in_data_byte = '0;
  logic        in_final_byte = 1'b0;
  logic        out_empty;
  logic        out_pop = 1'b0;
  logic [2:0]  out_token_kind;
  logic [31:0] out_token_offset;
  logic [31:0] out_token_length;
  logic        out_run_last;

  tokenizer_scoreboard sb = new();
  logic [7:0] text[$];
  logic [7:0] blanks[5] = '{8'd9, 8'd10, 8'd12, 8'd13, 8'd32};
  bit         hold_req = 0;
  bit         steady = 0;
  int         bytes_sent = 0;
  int         buffers_sent = 0;
  int         directed_bytes;

  bracket_raw_string_tokenizer_top DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_push          (in_push),
    .in_full          (in_full),
    .in_data_byte     (in_data_byte),
    .in_final_byte    (in_final_byte),
    .out_empty        (out_empty),
    .out_pop          (out_pop),
    .out_token_kind   (out_token_kind),
    .out_token_offset (out_token_offset),
    .out_token_length (out_token_length),
    .out_run_last     (out_run_last)
  );

  always #(HALF_PERIOD) clk = ~clk;

  // idle length: mostly none, sometimes short, rarely long
  function automatic int idle_len();
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 25);
  endfunction

  // printable non-bracket byte, sometimes from the upper range
  function automatic logic [7:0] word_char();
    logic [7:0] c;
    do begin
      if ($urandom_range(0, 5) == 0) c = 8'($urandom_range(160, 253));
      else c = 8'($urandom_range(33, 126));
    end while (c == CH_LBRACK || c == CH_RBRACK);
    return c;
  endfunction

  // delimiter byte: anything but an opening parenthesis
  function automatic logic [7:0] delim_char();
    logic [7:0] c;
    c = ($urandom_range(0, 7) == 0) ? 8'($urandom_range(0, 255)) : word_char();
    if (c == CH_LPAREN) c = 8'h64;
    return c;
  endfunction

  task automatic load_text(input string s);
    text.delete();
    for (int i = 0; i < s.len(); i++) text.push_back(s[i]);
  endtask

  // push the bytes of text as one buffer, final flag on the last
  task automatic send_buffer();
    int gap;
    for (int i = 0; i < text.size(); i++) begin
      in_push <= 1'b1;
      in_data_byte <= text[i];
      in_final_byte <= (i == text.size() - 1);
      do @(posedge clk); while (in_full);
      sb.scan_byte(text[i], i == text.size() - 1);
      bytes_sent++;
      gap = idle_len();
      if (gap > 0) begin
        in_push <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    buffers_sent++;
  endtask

  // random buffer: mostly well formed tokens, some lone R and stray bytes
  task automatic compose_buffer();
    logic [7:0] delim[$];
    int dl;
    int r;
    int k;
    text.delete();
    repeat ($urandom_range(1, 6)) begin
      case ($urandom_range(0, 11))
        0, 1: text.push_back($urandom_range(0, 1) ? CH_LBRACK : CH_RBRACK);
        2, 3, 4: repeat ($urandom_range(1, 6)) text.push_back(word_char());
        5, 6, 7, 8: begin
          // raw string with decoy closers, usually terminated
          r = $urandom_range(0, 19);
          dl = (r == 0) ? $urandom_range(17, 18) : (r < 3) ? MAX_DELIM : $urandom_range(0, 4);
          delim.delete();
          repeat (dl) delim.push_back(delim_char());
          text.push_back(CH_R);
          text.push_back(CH_QUOTE);
          foreach (delim[i]) text.push_back(delim[i]);
          text.push_back(CH_LPAREN);
          repeat ($urandom_range(0, 5)) begin
            case ($urandom_range(0, 3))
              0: text.push_back(8'($urandom_range(0, 255)));
              1: repeat (3) text.push_back(word_char());
              default: begin
                text.push_back(CH_RPAREN);
                k = (dl > 0) ? $urandom_range(0, dl - 1) : 0;
                for (int i = 0; i < k; i++) text.push_back(delim[i]);
                if (dl == 0 || $urandom_range(0, 1)) text.push_back(word_char());
                text.push_back(CH_QUOTE);
              end
            endcase
          end
          if ($urandom_range(0, 9) != 0) begin
            text.push_back(CH_RPAREN);
            foreach (delim[i]) text.push_back(delim[i]);
            text.push_back(CH_QUOTE);
          end
        end
        9: repeat ($urandom_range(1, 3)) text.push_back(blanks[$urandom_range(0, 4)]);
        10: begin
          text.push_back(CH_R);
          if ($urandom_range(0, 1)) text.push_back(word_char());
        end
        default: begin
          if ($urandom_range(0, 2) == 0) text.push_back(8'($urandom_range(0, 255)));
          else text.push_back(blanks[$urandom_range(0, 4)]);
        end
      endcase
      if ($urandom_range(0, 1)) text.push_back(blanks[$urandom_range(0, 4)]);
    end
  endtask

  // sender
  initial begin : stimulus
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // bracket, bad byte between tokens, then bytes dropped to the final one
    text = '{CH_LBRACK, 8'h00, 8'hFF};
    send_buffer();
    // bad byte right after a basic string
    load_text("ab");
    text.push_back(8'h7F);
    send_buffer();
    // raw string with a decoy closer before the real one
    load_text("R\"x(a)y\")x\"");
    text.push_front(8'd13);
    send_buffer();
    // lone R then a bracket on the final byte: three tokens at once
    load_text("Rq]");
    send_buffer();
    // lone R as the whole buffer
    load_text("R");
    send_buffer();
    // raw string still open at the final byte
    load_text("R\"(");
    send_buffer();
    // delimiter one byte too long
    load_text("R\"abcdefghijklmnopq)");
    send_buffer();
    directed_bytes = bytes_sent;

    while (bytes_sent < directed_bytes + RANDOM_BYTES) begin
      steady = ($urandom_range(0, 3) == 0);
      if (buffers_sent == 10) begin
        // burst of bracket tokens while the receiver holds off
        text.delete();
        repeat (16) text.push_back($urandom_range(0, 1) ? CH_LBRACK : CH_RBRACK);
        steady = 1;
        hold_req = 1;
      end else begin
        compose_buffer();
      end
      if (buffers_sent == 8 || buffers_sent == 20) begin
        // let the block run dry before the next buffer
        in_push <= 1'b0;
        do @(posedge clk); while (sb.outstanding() != 0);
      end
      send_buffer();
    end
    in_push <= 1'b0;

    while (sb.outstanding() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("covered %0d bytes in %0d buffers, %0d tokens popped", bytes_sent, buffers_sent,
             sb.checked);
    $display("tokens: %0d left, %0d right, %0d basic, %0d raw, %0d error, %0d end",
             sb.kind_seen[KIND_LEFT], sb.kind_seen[KIND_RIGHT], sb.kind_seen[KIND_BASIC],
             sb.kind_seen[KIND_RAW], sb.kind_seen[KIND_ERROR], sb.kind_seen[KIND_END]);
    if (sb.mismatches == 0 && sb.outstanding() == 0) begin
      $display("status: pass");
    end else begin
      $display("%0d mismatches, %0d tokens missing", sb.mismatches, sb.outstanding());
      $display("status: fail");
    end
    $finish;
  end

  // receiver with random pop gaps and one long hold-off
  initial begin : token_sink
    int gap;
    int hold_left;
    gap = 0;
    hold_left = 0;
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      out_pop <= (hold_left == 0) && (gap == 0);
      @(posedge clk);
      if (out_pop && !out_empty) begin
        sb.check_token(out_token_kind, out_token_offset, out_token_length, out_run_last);
        gap = idle_len();
      end else if (hold_left > 0) begin
        hold_left--;
      end else if (gap > 0) begin
        gap--;
      end
      if (hold_req) begin
        hold_left = LONG_HOLD;
        hold_req = 0;
      end
    end
  end

  // watchdog on cycles in which no request moves on either side
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_push && !in_full) || (out_pop && !out_empty)) quiet = 0;
      else quiet++;
    end
    $display("timeout: %0d cycles without a request, %0d tokens outstanding", quiet,
             sb.outstanding());
    $display("status: fail");
    $finish;
  end

endmodule

@@ bracket_raw_string_tokenizer_top.f @@
design/brt_pkg.sv
design/brt_front.sv
design/brt_fifo.sv
design/brt_back.sv
design/bracket_raw_string_tokenizer_top.sv
test/bracket_raw_string_tokenizer_top_tb.sv
